// File: design/lavb_pkg.sv
// ----------------------------------------------------------------------------
// lavb_pkg: shared constants for the look-at / billboard matrix unit
// Matrix codes, row counts and the fixed geometry of the normalizer pipeline.
// ----------------------------------------------------------------------------
package lavb_pkg;

  // Width of the magnitude word searched for its leading one, and group size.
  localparam int LZ_W   = 64;
  localparam int LZ_GRP = 8;

  // Scaled magnitudes have their leading one at this bit position.
  localparam int NORM_MSB = 30;

  // One square-root result bit per stage over a 64-bit radicand.
  localparam int SQRT_STEPS = 32;

  // Twelve result rows per request.
  localparam int ROWS = 12;
  typedef logic [3:0] row_cnt_t;
  localparam row_cnt_t LAST_ROW = row_cnt_t'(ROWS - 1);

  // Matrix codes carried on the result channel.
  localparam logic [1:0] MAT_VIEW = 2'd0;
  localparam logic [1:0] MAT_FULL = 2'd1;
  localparam logic [1:0] MAT_YBB  = 2'd2;

endpackage

// File: design/lavb_norm.sv
// ----------------------------------------------------------------------------
// lavb_norm: pipelined 3-vector normalizer
// Scales the magnitudes to a leading one at bit 30, takes the integer square
// root of the sum of squares and divides each component by it, one result
// bit per stage. A sideband word travels with each vector.
// ----------------------------------------------------------------------------
module lavb_norm #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [IN_W-1:0]   in_vec [3],
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_vld,
  output logic signed [FRAC_BITS+2:0] out_vec [3],
  output logic                     out_zero,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int PW  = lavb_pkg::LZ_W;
  localparam int GR  = lavb_pkg::LZ_GRP;
  localparam int NG  = PW / GR;
  localparam int MSB = lavb_pkg::NORM_MSB;
  localparam int MW  = MSB + 1;
  localparam int SQ  = lavb_pkg::SQRT_STEPS;
  localparam int QW  = FRAC_BITS + 2;
  localparam int DW  = QW + 32;

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               zero;
    logic [SIDE_W-1:0]  side;
  } carry_t;

  // Stage 1: magnitudes.
  logic [2:0][PW-1:0] s1_m_r;
  logic [2:0]         s1_neg_r;
  logic [SIDE_W-1:0]  s1_side_r;
  logic               s1_v_r;
  logic [2:0][IN_W-1:0] mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  // Stage 2: highest nonzero byte of the OR of the magnitudes.
  logic [PW-1:0]      or_v;
  logic [2:0]         grp_sel;
  logic [GR-1:0]      grp_byte;
  logic [2:0]         s2_g_r;
  logic [GR-1:0]      s2_byte_r;
  logic               s2_zero_r;
  logic [2:0][PW-1:0] s2_m_r;
  logic [2:0]         s2_neg_r;
  logic [SIDE_W-1:0]  s2_side_r;
  logic               s2_v_r;

  always_comb begin
    or_v     = s1_m_r[0] | s1_m_r[1] | s1_m_r[2];
    grp_sel  = '0;
    grp_byte = or_v[GR-1:0];
    for (int g = 0; g < NG; g++) begin
      if (|or_v[g*GR +: GR]) begin
        grp_sel  = 3'(g);
        grp_byte = or_v[g*GR +: GR];
      end
    end
  end

  // Stage 3: bit within that byte.
  logic [2:0]         bit_sel;
  logic [5:0]         s3_p_r;
  logic               s3_zero_r;
  logic [2:0][PW-1:0] s3_m_r;
  logic [2:0]         s3_neg_r;
  logic [SIDE_W-1:0]  s3_side_r;
  logic               s3_v_r;

  always_comb begin
    bit_sel = '0;
    for (int b = 0; b < GR; b++) begin
      if (s2_byte_r[b]) bit_sel = 3'(b);
    end
  end

  // Stage 4: scale so the largest magnitude lands in [2^30, 2^31).
  carry_t             s4_c_r;
  logic               s4_v_r;
  logic [2:0][MW-1:0] scaled;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_p_r >= 6'(MSB)) begin
        scaled[i] = MW'(s3_m_r[i] >> (s3_p_r - 6'(MSB)));
      end else begin
        scaled[i] = MW'(s3_m_r[i] << (6'(MSB) - s3_p_r));
      end
    end
  end

  // Stage 5: squares. Stage 6: their sum feeds the square-root chain.
  logic [2:0][2*MW-1:0] s5_sq_r;
  carry_t               s5_c_r;
  logic                 s5_v_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_m_r[i]   <= PW'(mag[i]);
      s1_neg_r[i] <= in_vec[i][IN_W-1];
    end
    s1_side_r <= in_side;

    s2_g_r    <= grp_sel;
    s2_byte_r <= grp_byte;
    s2_zero_r <= (or_v == '0);
    s2_m_r    <= s1_m_r;
    s2_neg_r  <= s1_neg_r;
    s2_side_r <= s1_side_r;

    s3_p_r    <= {s2_g_r, bit_sel};
    s3_zero_r <= s2_zero_r;
    s3_m_r    <= s2_m_r;
    s3_neg_r  <= s2_neg_r;
    s3_side_r <= s2_side_r;

    s4_c_r.m    <= scaled;
    s4_c_r.neg  <= s3_neg_r;
    s4_c_r.zero <= s3_zero_r;
    s4_c_r.side <= s3_side_r;

    for (int i = 0; i < 3; i++) begin
      s5_sq_r[i] <= s4_c_r.m[i] * s4_c_r.m[i];
    end
    s5_c_r <= s4_c_r;
  end

  // Square root: restoring form, one result bit per stage.
  logic [63:0] sq_n_r   [0:SQ];
  logic [63:0] sq_res_r [0:SQ];
  carry_t      sq_c_r   [0:SQ];
  logic        sq_v_r   [0:SQ];
  logic [63:0] sq_trial [0:SQ-1];

  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      sq_trial[k] = sq_res_r[k] + (64'd1 << (62 - 2*k));
    end
  end

  always_ff @(posedge clk) begin
    sq_n_r[0]   <= 64'(s5_sq_r[0]) + 64'(s5_sq_r[1]) + 64'(s5_sq_r[2]);
    sq_res_r[0] <= '0;
    sq_c_r[0]   <= s5_c_r;
    for (int k = 0; k < SQ; k++) begin
      if (sq_n_r[k] >= sq_trial[k]) begin
        sq_n_r[k+1]   <= sq_n_r[k] - sq_trial[k];
        sq_res_r[k+1] <= (sq_res_r[k] >> 1) + (64'd1 << (62 - 2*k));
      end else begin
        sq_n_r[k+1]   <= sq_n_r[k];
        sq_res_r[k+1] <= sq_res_r[k] >> 1;
      end
      sq_c_r[k+1] <= sq_c_r[k];
    end
  end

  // Division: rounded quotient of (m << F) by the length, three lanes.
  logic [2:0][DW-1:0] dv_rem_r [0:QW];
  logic [2:0][QW-1:0] dv_q_r   [0:QW];
  logic [31:0]        dv_len_r [0:QW];
  carry_t             dv_c_r   [0:QW];
  logic               dv_v_r   [0:QW];
  logic [DW-1:0]      dv_sub   [0:QW-1];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      dv_sub[j] = DW'(dv_len_r[j]) << (QW - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    dv_len_r[0] <= sq_res_r[SQ][31:0];
    dv_c_r[0]   <= sq_c_r[SQ];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= (DW'(sq_c_r[SQ].m[i]) << FRAC_BITS) + DW'(sq_res_r[SQ][31:1]);
      dv_q_r[0][i]   <= '0;
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= dv_sub[j]) begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i] - dv_sub[j];
          dv_q_r[j+1][i]   <= dv_q_r[j][i] | (QW'(1) << (QW - 1 - j));
        end else begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= dv_q_r[j][i];
        end
      end
      dv_len_r[j+1] <= dv_len_r[j];
      dv_c_r[j+1]   <= dv_c_r[j];
    end

    // Sign restore; a zero vector gives zero.
    for (int i = 0; i < 3; i++) begin
      if (dv_c_r[QW].zero) begin
        out_vec[i] <= '0;
      end else if (dv_c_r[QW].neg[i]) begin
        out_vec[i] <= -$signed({1'b0, dv_q_r[QW][i]});
      end else begin
        out_vec[i] <= $signed({1'b0, dv_q_r[QW][i]});
      end
    end
    out_zero <= dv_c_r[QW].zero;
    out_side <= dv_c_r[QW].side;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_vld <= 1'b0;
      for (int k = 0; k <= SQ; k++) sq_v_r[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv_v_r[j] <= 1'b0;
    end else begin
      s1_v_r    <= in_vld;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      sq_v_r[0] <= s5_v_r;
      for (int k = 0; k < SQ; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[SQ];
      for (int j = 0; j < QW; j++) dv_v_r[j+1] <= dv_v_r[j];
      out_vld <= dv_v_r[QW];
    end
  end

endmodule

// File: design/look_at_view_and_billboard_matrices_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_and_billboard_matrices_unit: left-handed camera matrices
// Rows: the twelve result rows of a request follow one another, one a cycle.
// Spacing: busy holds off the next request until the one-row-per-cycle result
//   port can take its rows; a new request can enter while others are in flight.
// Fixed point: FRAC_BITS fraction bits on 32-bit ports, Q16.16 at the default.
// Reset: synchronous, active low; clears all valid bits and counters.
// ----------------------------------------------------------------------------
module look_at_view_and_billboard_matrices_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic signed [31:0] in_offset_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic               out_valid,
  output logic [1:0]         out_matrix_id,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_degenerate,
  output logic               out_last_row
);

  // Normalized components carry FRAC_BITS+3 signed bits (magnitude up to 1.0
  // plus rounding headroom).
  localparam int OW  = FRAC_BITS + 3;
  localparam int XW  = 33 + OW;        // exact up x Z
  localparam int PW2 = 2 * OW;         // product of two unit components
  localparam int YW  = PW2 + 1;        // exact Z x X, and X x U before rounding
  localparam int DPW = OW + 34;        // unit component times negated eye
  localparam int DTW = OW + 36;        // dot product sum
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic [2:0][32:0]   eye;
    logic [2:0][OW-1:0] az;
    logic [2:0][OW-1:0] un;
    logic               dzz;
    logic               upz;
  } xside_t;

  typedef struct packed {
    logic [2:0][32:0]   eye;
    logic [2:0][OW-1:0] az;
    logic [2:0][OW-1:0] ax;
    logic [2:0][OW-1:0] un;
    logic               degen;
  } yside_t;

  typedef struct packed {
    logic [2:0][OW-1:0] ax;
    logic [2:0][OW-1:0] ay;
    logic [2:0][OW-1:0] az;
    logic [2:0][OW-1:0] un;
    logic               degen;
  } fside_t;

  // Rounds a value with FRAC_BITS extra fraction bits, half away from zero.
  function automatic logic signed [63:0] round_f(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Request intake. The offset cancels in target - eye, so the view direction
  // is taken straight from the raw inputs; the shifted eye is kept for the
  // translation row. Busy spaces the requests apart so the row serializer at
  // the end never sees two matrix sets overlap.
  // --------------------------------------------------------------------------
  logic                in_fire;
  lavb_pkg::row_cnt_t  gap_r;
  logic [2:0][32:0]    t1_eye_r;
  logic signed [32:0]  t1_dz_r [3];
  logic signed [31:0]  t1_up_r [3];
  logic                t1_v_r;

  assign busy    = (gap_r != '0);
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= '0;
      t1_v_r <= 1'b0;
    end else begin
      t1_v_r <= in_fire;
      if (in_fire) begin
        gap_r <= lavb_pkg::LAST_ROW;
      end else if (gap_r != '0) begin
        gap_r <= gap_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      t1_eye_r[0] <= {in_eye_x[31], in_eye_x} + {in_offset_x[31], in_offset_x};
      t1_eye_r[1] <= {in_eye_y[31], in_eye_y} + {in_offset_y[31], in_offset_y};
      t1_eye_r[2] <= {in_eye_z[31], in_eye_z} + {in_offset_z[31], in_offset_z};
      t1_dz_r[0]  <= {in_target_x[31], in_target_x} - {in_eye_x[31], in_eye_x};
      t1_dz_r[1]  <= {in_target_y[31], in_target_y} - {in_eye_y[31], in_eye_y};
      t1_dz_r[2]  <= {in_target_z[31], in_target_z} - {in_eye_z[31], in_eye_z};
      t1_up_r[0]  <= in_up_x;
      t1_up_r[1]  <= in_up_y;
      t1_up_r[2]  <= in_up_z;
    end
  end

  // --------------------------------------------------------------------------
  // Z axis and the normalized up vector are formed side by side; both units
  // have the same latency, so their outputs line up.
  // --------------------------------------------------------------------------
  logic                na_v, na_zero, nu_v, nu_zero;
  logic signed [OW-1:0] na_vec [3];
  logic signed [OW-1:0] nu_vec [3];
  logic [95:0]         na_side;
  logic [2:0][32:0]    nu_eye;

  lavb_norm #(.IN_W(33), .FRAC_BITS(FRAC_BITS), .SIDE_W(96)) u_norm_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t1_v_r),
    .in_vec  (t1_dz_r),
    .in_side ({t1_up_r[2], t1_up_r[1], t1_up_r[0]}),
    .out_vld (na_v),
    .out_vec (na_vec),
    .out_zero(na_zero),
    .out_side(na_side)
  );

  lavb_norm #(.IN_W(32), .FRAC_BITS(FRAC_BITS), .SIDE_W(99)) u_norm_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (t1_v_r),
    .in_vec  (t1_up_r),
    .in_side (t1_eye_r),
    .out_vld (nu_v),
    .out_vec (nu_vec),
    .out_zero(nu_zero),
    .out_side(nu_eye)
  );

  // --------------------------------------------------------------------------
  // Up x Z, kept exact: products in one stage, differences in the next.
  // --------------------------------------------------------------------------
  logic signed [31:0]       up_a [3];
  logic signed [32+OW-1:0]  c1_pa_r [3];
  logic signed [32+OW-1:0]  c1_pb_r [3];
  xside_t                   c1_s_r, c2_s_r;
  logic                     c1_v_r, c2_v_r;
  logic signed [XW-1:0]     c2_x_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) up_a[i] = $signed(na_side[32*i +: 32]);
  end

  always_ff @(posedge clk) begin
    c1_pa_r[0] <= up_a[1] * na_vec[2];
    c1_pb_r[0] <= up_a[2] * na_vec[1];
    c1_pa_r[1] <= up_a[2] * na_vec[0];
    c1_pb_r[1] <= up_a[0] * na_vec[2];
    c1_pa_r[2] <= up_a[0] * na_vec[1];
    c1_pb_r[2] <= up_a[1] * na_vec[0];
    c1_s_r.eye <= nu_eye;
    for (int i = 0; i < 3; i++) begin
      c1_s_r.az[i] <= na_vec[i];
      c1_s_r.un[i] <= nu_vec[i];
    end
    c1_s_r.dzz <= na_zero;
    c1_s_r.upz <= nu_zero;

    for (int i = 0; i < 3; i++) c2_x_r[i] <= XW'(c1_pa_r[i]) - XW'(c1_pb_r[i]);
    c2_s_r <= c1_s_r;
  end

  // X axis.
  logic                 nx_v, nx_zero;
  logic signed [OW-1:0] nx_vec [3];
  xside_t               nx_s;

  lavb_norm #(.IN_W(XW), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(xside_t))) u_norm_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c2_v_r),
    .in_vec  (c2_x_r),
    .in_side (c2_s_r),
    .out_vld (nx_v),
    .out_vec (nx_vec),
    .out_zero(nx_zero),
    .out_side(nx_s)
  );

  // --------------------------------------------------------------------------
  // Z x X, exact, then the Y axis.
  // --------------------------------------------------------------------------
  logic signed [PW2-1:0] c3_pa_r [3];
  logic signed [PW2-1:0] c3_pb_r [3];
  logic signed [OW-1:0]  azx [3];
  yside_t                c3_s_r, c4_s_r;
  logic                  c3_v_r, c4_v_r;
  logic signed [YW-1:0]  c4_y_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) azx[i] = $signed(nx_s.az[i]);
  end

  always_ff @(posedge clk) begin
    c3_pa_r[0] <= azx[1] * nx_vec[2];
    c3_pb_r[0] <= azx[2] * nx_vec[1];
    c3_pa_r[1] <= azx[2] * nx_vec[0];
    c3_pb_r[1] <= azx[0] * nx_vec[2];
    c3_pa_r[2] <= azx[0] * nx_vec[1];
    c3_pb_r[2] <= azx[1] * nx_vec[0];
    c3_s_r.eye <= nx_s.eye;
    c3_s_r.az  <= nx_s.az;
    c3_s_r.un  <= nx_s.un;
    for (int i = 0; i < 3; i++) c3_s_r.ax[i] <= nx_vec[i];
    // A zero X axis can only come from a zero up x Z.
    c3_s_r.degen <= nx_s.dzz || nx_s.upz || nx_zero;

    for (int i = 0; i < 3; i++) c4_y_r[i] <= YW'(c3_pa_r[i]) - YW'(c3_pb_r[i]);
    c4_s_r <= c3_s_r;
  end

  logic                 ny_v, ny_zero;
  logic signed [OW-1:0] ny_vec [3];
  yside_t               ny_s;

  lavb_norm #(.IN_W(YW), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(yside_t))) u_norm_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c4_v_r),
    .in_vec  (c4_y_r),
    .in_side (c4_s_r),
    .out_vld (ny_v),
    .out_vec (ny_vec),
    .out_zero(ny_zero),
    .out_side(ny_s)
  );

  // --------------------------------------------------------------------------
  // Finish: X x U for the y-axis billboard, and the three translation dot
  // products against the negated shifted eye. Products, then sums, then the
  // rounding and saturation that load the row buffer.
  // --------------------------------------------------------------------------
  logic signed [OW-1:0]  axs [3][3];   // [axis][component]: X, Y, Z
  logic signed [OW-1:0]  unf [3];
  logic signed [33:0]    neye [3];
  logic signed [PW2-1:0] f1_ya_r [3];
  logic signed [PW2-1:0] f1_yb_r [3];
  logic signed [DPW-1:0] f1_d_r [3][3];
  fside_t                f1_s_r, f2_s_r;
  logic                  f1_v_r, f2_v_r;
  logic signed [YW-1:0]  f2_yz_r [3];
  logic signed [DTW-1:0] f2_t_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axs[0][i] = $signed(ny_s.ax[i]);
      axs[1][i] = ny_vec[i];
      axs[2][i] = $signed(ny_s.az[i]);
      unf[i]    = $signed(ny_s.un[i]);
      neye[i]   = -$signed({ny_s.eye[i][32], ny_s.eye[i]});
    end
  end

  always_ff @(posedge clk) begin
    f1_ya_r[0] <= axs[0][1] * unf[2];
    f1_yb_r[0] <= axs[0][2] * unf[1];
    f1_ya_r[1] <= axs[0][2] * unf[0];
    f1_yb_r[1] <= axs[0][0] * unf[2];
    f1_ya_r[2] <= axs[0][0] * unf[1];
    f1_yb_r[2] <= axs[0][1] * unf[0];
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) f1_d_r[a][i] <= axs[a][i] * neye[i];
    end
    for (int i = 0; i < 3; i++) begin
      f1_s_r.ax[i] <= axs[0][i];
      f1_s_r.ay[i] <= axs[1][i];
      f1_s_r.az[i] <= axs[2][i];
      f1_s_r.un[i] <= unf[i];
    end
    f1_s_r.degen <= ny_s.degen;

    for (int i = 0; i < 3; i++) begin
      f2_yz_r[i] <= YW'(f1_ya_r[i]) - YW'(f1_yb_r[i]);
      f2_t_r[i]  <= DTW'(f1_d_r[i][0]) + DTW'(f1_d_r[i][1]) + DTW'(f1_d_r[i][2]);
    end
    f2_s_r <= f1_s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      c1_v_r <= na_v && nu_v;
      c2_v_r <= c1_v_r;
      c3_v_r <= nx_v;
      c4_v_r <= c3_v_r;
      f1_v_r <= ny_v;
      f2_v_r <= f1_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Row buffer and serializer. The buffer loads when a finished request
  // arrives, and the counter then walks the twelve rows, one per cycle:
  // bits [3:2] give the matrix and bits [1:0] the row.
  // --------------------------------------------------------------------------
  logic [2:0][31:0]   ob_ax_r, ob_ay_r, ob_az_r, ob_un_r, ob_yz_r, ob_t_r;
  logic               ob_degen_r;
  logic               act_r;
  lavb_pkg::row_cnt_t rc_r;
  logic [31:0]        yz_ext;

  always_ff @(posedge clk) begin
    if (f2_v_r) begin
      for (int i = 0; i < 3; i++) begin
        ob_ax_r[i] <= 32'(signed'(f2_s_r.ax[i]));
        ob_ay_r[i] <= 32'(signed'(f2_s_r.ay[i]));
        ob_az_r[i] <= 32'(signed'(f2_s_r.az[i]));
        ob_un_r[i] <= 32'(signed'(f2_s_r.un[i]));
        ob_yz_r[i] <= 32'(round_f(64'(f2_yz_r[i])));
        ob_t_r[i]  <= sat32(round_f(64'(f2_t_r[i])));
      end
      ob_degen_r <= f2_s_r.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      rc_r  <= '0;
    end else if (f2_v_r) begin
      act_r <= 1'b1;
      rc_r  <= '0;
    end else if (act_r) begin
      if (rc_r == lavb_pkg::LAST_ROW) begin
        act_r <= 1'b0;
      end else begin
        rc_r <= rc_r + 1'b1;
      end
    end
  end

  // Row assembly from the buffer.
  logic [3:0][31:0] col;
  logic [2:0][31:0] vec;
  assign yz_ext = '0;

  always_comb begin
    col = '0;
    vec = '0;
    case (out_matrix_id)
      lavb_pkg::MAT_VIEW: begin
        if (out_row_index == 2'd3) begin
          col = {ONE, ob_t_r[2], ob_t_r[1], ob_t_r[0]};
        end else begin
          col = {yz_ext, ob_az_r[out_row_index], ob_ay_r[out_row_index],
                 ob_ax_r[out_row_index]};
        end
      end
      lavb_pkg::MAT_FULL, lavb_pkg::MAT_YBB: begin
        case (out_row_index)
          2'd0: vec = ob_ax_r;
          2'd1: vec = (out_matrix_id == lavb_pkg::MAT_FULL) ? ob_ay_r : ob_un_r;
          2'd2: vec = (out_matrix_id == lavb_pkg::MAT_FULL) ? ob_az_r : ob_yz_r;
          default: vec = '0;
        endcase
        if (out_row_index == 2'd3) begin
          col = {ONE, 32'd0, 32'd0, 32'd0};
        end else begin
          col = {32'd0, vec[2], vec[1], vec[0]};
        end
      end
      default: col = '0;
    endcase
    // A degenerate camera clears every element, the 1.0 entries included.
    if (ob_degen_r) col = '0;
  end

  assign out_valid      = act_r;
  assign out_matrix_id  = rc_r[3:2];
  assign out_row_index  = rc_r[1:0];
  assign out_col0       = col[0];
  assign out_col1       = col[1];
  assign out_col2       = col[2];
  assign out_col3       = col[3];
  assign out_degenerate = ob_degen_r;
  assign out_last_row   = (rc_r == lavb_pkg::LAST_ROW);

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A finished request may only load the buffer as the previous run ends.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r |-> (!act_r || rc_r == lavb_pkg::LAST_ROW))
    else $error("row buffer reloaded while rows were still being sent");

  // An accepted request holds off the next one.
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy)
    else $error("busy not raised after an accepted request");

  // The last row is row 3 of the y-axis billboard.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |->
      (out_matrix_id == lavb_pkg::MAT_YBB && out_row_index == 2'd3))
    else $error("last row flag on the wrong row");

  // Degenerate rows are all zero.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_col0 == '0 && out_col1 == '0 && out_col2 == '0 && out_col3 == '0))
    else $error("degenerate row carries nonzero elements");

  // With unit Z and X axes, their cross product can never vanish.
  a_y_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (ny_v && !ny_s.degen) |-> !ny_zero)
    else $error("zero Y axis on a camera that is not degenerate");

endmodule

// File: tb/look_at_view_and_billboard_matrices_unit_test.sv
// ----------------------------------------------------------------------------
// look_at_view_and_billboard_matrices_unit_test: camera matrix unit testbench
// Sends eye, target, shift and up vectors to the unit and checks all twelve
// matrix rows of every request against a bit-accurate predictor.
// ----------------------------------------------------------------------------
module look_at_view_and_billboard_matrices_unit_test;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 210;

  // One expected or observed matrix row.
  typedef struct packed {
    logic [1:0]  matrix_id;
    logic [1:0]  row_index;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] col3;
    logic        degenerate;
    logic        last_row;
  } matrix_row_t;

  // One camera update request.
  typedef struct {
    logic signed [31:0] eye[3];
    logic signed [31:0] target[3];
    logic signed [31:0] offset[3];
    logic signed [31:0] up[3];
  } camera_req_t;

  // The scoreboard predicts the rows of each accepted request and checks the
  // rows the unit returns against them in order.
  class camera_scoreboard;
    matrix_row_t pending_rows[$];
    int mismatches;
    int rows_checked;
    int degenerate_rows;

    function new();
      mismatches = 0;
      rows_checked = 0;
      degenerate_rows = 0;
    endfunction

    static function longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // Divide by 2^FRAC with rounding half away from zero.
    static function longint round_frac(longint v);
      longint unsigned m;
      m = (abs64(v) + (64'd1 << (FRAC - 1))) >> FRAC;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Unit vector in fixed point; magnitudes are rescaled so the largest lies
    // in [2^30, 2^31) before the length is taken.
    static function void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = abs64(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return;
      end
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      while (mx >= (64'd1 << 31)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FRAC) + (len >> 1)) / len;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    static function void cross_vec(input longint a[3], input longint b[3],
                                   output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Notes an accepted request and queues its twelve expected rows.
    function void note_request(camera_req_t rq);
      longint eye[3], dz[3], up[3], ax[3], ay[3], az[3], un[3], yz[3];
      longint tr[3], tmp[3], d;
      longint mat[3][4][4];
      bit degen;
      matrix_row_t row;
      for (int i = 0; i < 3; i++) begin
        eye[i] = longint'(rq.eye[i]) + longint'(rq.offset[i]);
        dz[i] = (longint'(rq.target[i]) + longint'(rq.offset[i])) - eye[i];
        up[i] = rq.up[i];
      end
      unit_vec(dz, az);
      cross_vec(up, az, tmp);
      unit_vec(tmp, ax);
      cross_vec(az, ax, tmp);
      unit_vec(tmp, ay);
      unit_vec(up, un);
      cross_vec(ax, un, tmp);
      for (int i = 0; i < 3; i++) yz[i] = round_frac(tmp[i]);
      for (int i = 0; i < 3; i++) begin
        d = 0;
        for (int k = 0; k < 3; k++) begin
          case (i)
            0: d += ax[k] * -eye[k];
            1: d += ay[k] * -eye[k];
            default: d += az[k] * -eye[k];
          endcase
        end
        tr[i] = clamp32(round_frac(d));
      end
      degen = (dz[0] == 0 && dz[1] == 0 && dz[2] == 0) ||
              (up[0] == 0 && up[1] == 0 && up[2] == 0) ||
              (ax[0] == 0 && ax[1] == 0 && ax[2] == 0);
      for (int m = 0; m < 3; m++)
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) mat[m][r][c] = 0;
      for (int r = 0; r < 3; r++) begin
        mat[0][r][0] = ax[r];
        mat[0][r][1] = ay[r];
        mat[0][r][2] = az[r];
        mat[0][3][r] = tr[r];
        mat[1][0][r] = ax[r];
        mat[1][1][r] = ay[r];
        mat[1][2][r] = az[r];
        mat[2][0][r] = ax[r];
        mat[2][1][r] = un[r];
        mat[2][2][r] = yz[r];
      end
      for (int m = 0; m < 3; m++) mat[m][3][3] = 64'sd1 << FRAC;
      for (int m = 0; m < 3; m++) begin
        for (int r = 0; r < 4; r++) begin
          row.matrix_id = m == 0 ? lavb_pkg::MAT_VIEW :
                          (m == 1 ? lavb_pkg::MAT_FULL : lavb_pkg::MAT_YBB);
          row.row_index = r[1:0];
          row.col0 = degen ? 32'd0 : mat[m][r][0][31:0];
          row.col1 = degen ? 32'd0 : mat[m][r][1][31:0];
          row.col2 = degen ? 32'd0 : mat[m][r][2][31:0];
          row.col3 = degen ? 32'd0 : mat[m][r][3][31:0];
          row.degenerate = degen;
          row.last_row = (m == 2 && r == 3);
          pending_rows.push_back(row);
        end
      end
    endfunction

    // Compares one returned row with the oldest expected row.
    function void check_row(matrix_row_t got);
      matrix_row_t want;
      rows_checked++;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected row %h", got);
        return;
      end
      want = pending_rows.pop_front();
      if (want.degenerate) degenerate_rows++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: row mismatch\n  expected %h\n  actual   %h", want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_eye_x, in_eye_y, in_eye_z;
  logic signed [31:0] in_target_x, in_target_y, in_target_z;
  logic signed [31:0] in_offset_x, in_offset_y, in_offset_z;
  logic signed [31:0] in_up_x, in_up_y, in_up_z;
  logic               out_valid;
  logic [1:0]         out_matrix_id;
  logic [1:0]         out_row_index;
  logic signed [31:0] out_col0, out_col1, out_col2, out_col3;
  logic               out_degenerate;
  logic               out_last_row;

  camera_scoreboard board;
  int requests_sent;

  look_at_view_and_billboard_matrices_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_eye_x      (in_eye_x),
    .in_eye_y      (in_eye_y),
    .in_eye_z      (in_eye_z),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .in_target_z   (in_target_z),
    .in_offset_x   (in_offset_x),
    .in_offset_y   (in_offset_y),
    .in_offset_z   (in_offset_z),
    .in_up_x       (in_up_x),
    .in_up_y       (in_up_y),
    .in_up_z       (in_up_z),
    .out_valid     (out_valid),
    .out_matrix_id (out_matrix_id),
    .out_row_index (out_row_index),
    .out_col0      (out_col0),
    .out_col1      (out_col1),
    .out_col2      (out_col2),
    .out_col3      (out_col3),
    .out_degenerate(out_degenerate),
    .out_last_row  (out_last_row)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // A request moves on the edge where start is high and busy is low. The
  // sampled values are those from before the edge, so the order of events
  // within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.note_request('{
        eye:    '{in_eye_x, in_eye_y, in_eye_z},
        target: '{in_target_x, in_target_y, in_target_z},
        offset: '{in_offset_x, in_offset_y, in_offset_z},
        up:     '{in_up_x, in_up_y, in_up_z}});
      requests_sent++;
    end
    if (rst_n && out_valid)
      board.check_row({out_matrix_id, out_row_index, out_col0, out_col1, out_col2,
                       out_col3, out_degenerate, out_last_row});
  end

  // Holds start high with the given request until the unit takes it; start is
  // left high on return, and the caller or idle_cycles drops it.
  task automatic send_request(camera_req_t rq);
    start       <= 1'b1;
    in_eye_x    <= rq.eye[0];
    in_eye_y    <= rq.eye[1];
    in_eye_z    <= rq.eye[2];
    in_target_x <= rq.target[0];
    in_target_y <= rq.target[1];
    in_target_z <= rq.target[2];
    in_offset_x <= rq.offset[0];
    in_offset_y <= rq.offset[1];
    in_offset_z <= rq.offset[2];
    in_up_x     <= rq.up[0];
    in_up_y     <= rq.up[1];
    in_up_z     <= rq.up[2];
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic camera_req_t make_req(
      logic signed [31:0] ex, ey, ez, tx, ty, tz,
      logic signed [31:0] ox, oy, oz, ux, uy, uz);
    camera_req_t rq;
    rq.eye = '{ex, ey, ez};
    rq.target = '{tx, ty, tz};
    rq.offset = '{ox, oy, oz};
    rq.up = '{ux, uy, uz};
    return rq;
  endfunction

  // Small Q16.16 values keep the geometry ordinary; full-width values drive
  // the exact sums, the normalizer scaling and the translation saturation.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 200)) - 100;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return ($signed($urandom_range(0, 65535)) - 32768) <<< 8;
    endcase
  endfunction

  function automatic camera_req_t rand_req();
    camera_req_t rq;
    int shape;
    shape = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      rq.eye[i] = rand_coord();
      rq.target[i] = rand_coord();
      rq.offset[i] = $urandom_range(0, 2) == 0 ? rand_coord() : 32'sd0;
      rq.up[i] = rand_coord();
    end
    // A few requests are made degenerate or nearly so on purpose.
    if (shape == 0) rq.target = rq.eye;
    if (shape == 1) rq.up = '{0, 0, 0};
    if (shape == 2) for (int i = 0; i < 3; i++) rq.up[i] = rq.target[i] - rq.eye[i];
    return rq;
  endfunction

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  initial begin
    camera_req_t rq;
    int burst;
    board = new();
    requests_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_eye_x, in_eye_y, in_eye_z} = '0;
    {in_target_x, in_target_y, in_target_z} = '0;
    {in_offset_x, in_offset_y, in_offset_z} = '0;
    {in_up_x, in_up_y, in_up_z} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ordinary camera, each degenerate cause, field extremes,
    // shifts that carry past 32 bits, and a large eye that saturates the
    // translation.
    send_request(make_req(0, 0, -5 * ONE, 0, 0, 0, 0, 0, 0, 0, ONE, 0));
    send_request(make_req(ONE, 2 * ONE, 3 * ONE, -ONE, 0, 4 * ONE, ONE, ONE, ONE,
                          0, ONE, 0));
    send_request(make_req(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0));
    send_request(make_req(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    send_request(make_req(0, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 3 * ONE));
    send_request(make_req(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 0, 0,
                          MAXV, MINV, MAXV));
    send_request(make_req(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV,
                          MINV, MINV, MINV));
    send_request(make_req(MINV, 0, MAXV, 0, MINV, 0, MINV, MINV, MINV,
                          0, MAXV, ONE));
    send_request(make_req(MAXV, MINV, MAXV, 0, 0, 0, 0, 0, 0, ONE, ONE, 0));
    send_request(make_req(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_request(make_req(-1, -1, -1, 32'shffff_ffff, 0, 1, -1, -1, -1,
                          -1, -1, -1));
    send_request(make_req(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678,
                          32'shaaaa_aaaa, 32'sh5555_5555, 32'shedcb_a987,
                          32'sh0f0f_0f0f, 32'shf0f0_f0f0, 0, 32'sh3333_3333,
                          32'shcccc_cccc, 32'sh7f00_00ff));

    // The sender holds off here until every pending row has come back.
    start <= 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk);

    // Random bursts with gaps; some bursts run back to back without a gap.
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        rq = rand_req();
        send_request(rq);
      end
      idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
    end
    start <= 1'b0;

    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (3 * FRAC + 160) @(posedge clk);

    $display("Covered %0d requests, %0d rows checked, %0d of them degenerate.",
             requests_sent, board.rows_checked, board.degenerate_rows);
    $display("Mismatches: %0d.", board.mismatches);
    if (board.mismatches == 0 && board.pending_rows.size() == 0) begin
      $display("PASS look_at_view_and_billboard_matrices_unit");
    end else begin
      $display("FAIL look_at_view_and_billboard_matrices_unit");
    end
    $finish;
  end

  // Watchdog: the 222 requests with their gaps and the pipeline fill come well
  // under this bound.
  initial begin
    #2000000;
    $display("ERROR: timeout");
    $display("FAIL look_at_view_and_billboard_matrices_unit");
    $finish;
  end

endmodule
